// ===== rtl/core/a64dec_pkg.sv =====
// Package for the AArch64 subset decoder: operation codes and match constants.
package a64dec_pkg;

  localparam int unsigned OpW = 6;

  // Dense operation codes, numbered in priority order of the decode checks
  typedef enum logic [OpW-1:0] {
    OP_UNKNOWN = 6'd0,
    OP_HLT     = 6'd1,
    OP_B       = 6'd2,
    OP_BR      = 6'd3,
    OP_LSR     = 6'd4,
    OP_LSL     = 6'd5,
    OP_MOVZ    = 6'd6,
    OP_ADDI    = 6'd7,
    OP_ADDSI   = 6'd8,
    OP_CMPI    = 6'd9,
    OP_SUBSI   = 6'd10,
    OP_BEQ     = 6'd11,
    OP_BNE     = 6'd12,
    OP_BGE     = 6'd13,
    OP_BLT     = 6'd14,
    OP_BGT     = 6'd15,
    OP_BLE     = 6'd16,
    OP_CBZ     = 6'd17,
    OP_CBNZ    = 6'd18,
    OP_ADDX    = 6'd19,
    OP_ADDSX   = 6'd20,
    OP_CMPX    = 6'd21,
    OP_SUBSX   = 6'd22,
    OP_ANDS    = 6'd23,
    OP_EOR     = 6'd24,
    OP_ORR     = 6'd25,
    OP_MUL     = 6'd26,
    OP_STUR    = 6'd27,
    OP_STURB   = 6'd28,
    OP_STURH   = 6'd29,
    OP_LDUR    = 6'd30,
    OP_LDURB   = 6'd31,
    OP_LDURH   = 6'd32
  } op_e;

  // Fixed-field match patterns
  localparam logic [10:0] HltTop11   = 11'h6A2;
  localparam logic [5:0]  BTop6      = 6'h05;
  localparam logic [21:0] BrMid22    = 22'h3587C0;
  localparam logic [9:0]  UbfmTop10  = 10'h34D;
  localparam logic [8:0]  MovzTop9   = 9'h1A5;
  localparam logic [5:0]  ImmsAll    = 6'h3F;
  localparam logic [4:0]  RegZr      = 5'h1F;

  // Opcode byte, bits 31:24
  localparam logic [7:0] TopAddI  = 8'h91;
  localparam logic [7:0] TopAddsI = 8'hB1;
  localparam logic [7:0] TopSubsI = 8'hF1;
  localparam logic [7:0] TopBCond = 8'h54;
  localparam logic [7:0] TopCbz   = 8'hB4;
  localparam logic [7:0] TopCbnz  = 8'hB5;

  // Branch condition codes
  localparam logic [3:0] CondEq = 4'h0;
  localparam logic [3:0] CondNe = 4'h1;
  localparam logic [3:0] CondGe = 4'hA;
  localparam logic [3:0] CondLt = 4'hB;
  localparam logic [3:0] CondGt = 4'hC;
  localparam logic [3:0] CondLe = 4'hD;

  // Opcode field, bits 31:21
  localparam logic [10:0] TopAddX  = 11'h459;
  localparam logic [10:0] TopAddsX = 11'h559;
  localparam logic [10:0] TopSubsX = 11'h759;
  localparam logic [10:0] TopAnds  = 11'h750;
  localparam logic [10:0] TopEor   = 11'h650;
  localparam logic [10:0] TopOrr   = 11'h550;
  localparam logic [10:0] TopMul   = 11'h1B7;
  localparam logic [10:0] TopStur  = 11'h7C0;
  localparam logic [10:0] TopSturb = 11'h1C0;
  localparam logic [10:0] TopSturh = 11'h3C0;
  localparam logic [10:0] TopLdur  = 11'h7C2;
  localparam logic [10:0] TopLdurb = 11'h1C2;
  localparam logic [10:0] TopLdurh = 11'h3C2;

endpackage

// ===== rtl/core/a64dec_decode.sv =====
// Combinational priority decode of one instruction word into an operation code.
module a64dec_decode (
  input  logic [31:0]      word_i,
  output a64dec_pkg::op_e  op_o
);

  logic [10:0] top11;
  logic [7:0]  top8;
  logic        rd_zr;
  logic [5:0]  immr;
  logic [5:0]  imms;
  logic [6:0]  imms_inc;
  logic        is_lsr;
  logic        is_lsl;
  a64dec_pkg::op_e bcond_op;
  a64dec_pkg::op_e reg_op;

  assign top11    = word_i[31:21];
  assign top8     = word_i[31:24];
  assign rd_zr    = (word_i[4:0] == a64dec_pkg::RegZr);
  assign immr     = word_i[21:16];
  assign imms     = word_i[15:10];
  assign imms_inc = {1'b0, imms} + 7'd1;

  // UBFM aliases
  assign is_lsr = (word_i[31:22] == a64dec_pkg::UbfmTop10) && (imms == a64dec_pkg::ImmsAll);
  assign is_lsl = (word_i[31:22] == a64dec_pkg::UbfmTop10) && (imms_inc == {1'b0, immr});

  // Conditional branch condition
  always_comb begin
    unique case (word_i[3:0])
      a64dec_pkg::CondEq: bcond_op = a64dec_pkg::OP_BEQ;
      a64dec_pkg::CondNe: bcond_op = a64dec_pkg::OP_BNE;
      a64dec_pkg::CondGe: bcond_op = a64dec_pkg::OP_BGE;
      a64dec_pkg::CondLt: bcond_op = a64dec_pkg::OP_BLT;
      a64dec_pkg::CondGt: bcond_op = a64dec_pkg::OP_BGT;
      a64dec_pkg::CondLe: bcond_op = a64dec_pkg::OP_BLE;
      default:            bcond_op = a64dec_pkg::OP_UNKNOWN;
    endcase
  end

  // Register, logical and load/store forms
  always_comb begin
    unique case (top11)
      a64dec_pkg::TopAddX:  reg_op = a64dec_pkg::OP_ADDX;
      a64dec_pkg::TopAddsX: reg_op = a64dec_pkg::OP_ADDSX;
      a64dec_pkg::TopSubsX: reg_op = rd_zr ? a64dec_pkg::OP_CMPX : a64dec_pkg::OP_SUBSX;
      a64dec_pkg::TopAnds:  reg_op = a64dec_pkg::OP_ANDS;
      a64dec_pkg::TopEor:   reg_op = a64dec_pkg::OP_EOR;
      a64dec_pkg::TopOrr:   reg_op = a64dec_pkg::OP_ORR;
      a64dec_pkg::TopMul:   reg_op = a64dec_pkg::OP_MUL;
      a64dec_pkg::TopStur:  reg_op = a64dec_pkg::OP_STUR;
      a64dec_pkg::TopSturb: reg_op = a64dec_pkg::OP_STURB;
      a64dec_pkg::TopSturh: reg_op = a64dec_pkg::OP_STURH;
      a64dec_pkg::TopLdur:  reg_op = a64dec_pkg::OP_LDUR;
      a64dec_pkg::TopLdurb: reg_op = a64dec_pkg::OP_LDURB;
      a64dec_pkg::TopLdurh: reg_op = a64dec_pkg::OP_LDURH;
      default:              reg_op = a64dec_pkg::OP_UNKNOWN;
    endcase
  end

  // Priority chain, first match wins
  always_comb begin
    if (top11 == a64dec_pkg::HltTop11) begin
      op_o = a64dec_pkg::OP_HLT;
    end else if (word_i[31:26] == a64dec_pkg::BTop6) begin
      op_o = a64dec_pkg::OP_B;
    end else if ((word_i[31:10] == a64dec_pkg::BrMid22) && (word_i[4:0] == 5'd0)) begin
      op_o = a64dec_pkg::OP_BR;
    end else if (is_lsr) begin
      op_o = a64dec_pkg::OP_LSR;
    end else if (is_lsl) begin
      op_o = a64dec_pkg::OP_LSL;
    end else if ((word_i[31:23] == a64dec_pkg::MovzTop9) && (word_i[22:21] == 2'd0)) begin
      op_o = a64dec_pkg::OP_MOVZ;
    end else if (top8 == a64dec_pkg::TopAddI) begin
      op_o = a64dec_pkg::OP_ADDI;
    end else if (top8 == a64dec_pkg::TopAddsI) begin
      op_o = a64dec_pkg::OP_ADDSI;
    end else if (top8 == a64dec_pkg::TopSubsI) begin
      op_o = rd_zr ? a64dec_pkg::OP_CMPI : a64dec_pkg::OP_SUBSI;
    end else if (top8 == a64dec_pkg::TopBCond) begin
      op_o = bcond_op;
    end else if (top8 == a64dec_pkg::TopCbz) begin
      op_o = a64dec_pkg::OP_CBZ;
    end else if (top8 == a64dec_pkg::TopCbnz) begin
      op_o = a64dec_pkg::OP_CBNZ;
    end else begin
      op_o = reg_op;
    end
  end

endmodule

// ===== rtl/core/arm64_subset_opcode_decoder.sv =====
// Top level: input register, decode, result register with valid/stall handshake.
// An accepted input transaction passes through the input register, then the result register, to the outputs.
// Throughput: one transaction per cycle while out_stall_i is low; set by the single input-to-result register pair.
// A stalled result holds in the result register while the input register takes one more.
// Reset (rst_ni low, asynchronous) empties both stages; payload registers are not reset.
module arm64_subset_opcode_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instruction_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  operation_code_o,
  output logic [31:0] word_passthrough_o
);

  logic            in_vld_q;
  logic [31:0]     in_word_q;
  logic            res_vld_q;
  logic [31:0]     res_word_q;
  a64dec_pkg::op_e res_op_q;
  a64dec_pkg::op_e dec_op;
  logic            res_en;
  logic            in_en;

  // Stage enables: a stage loads when empty or when its contents move on
  assign res_en     = !res_vld_q || !out_stall_i;
  assign in_en      = !in_vld_q || res_en;
  assign in_stall_o = !in_en;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      in_word_q <= instruction_word_i;
    end
  end

  a64dec_decode u_decode (
    .word_i (in_word_q),
    .op_o   (dec_op)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_en) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en && in_vld_q) begin
      res_op_q   <= dec_op;
      res_word_q <= in_word_q;
    end
  end

  assign out_valid_o        = res_vld_q;
  assign operation_code_o   = res_op_q;
  assign word_passthrough_o = res_word_q;

  // Stall only when the input stage is full and cannot drain
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && res_vld_q && out_stall_i))
    else $error("input stalled while a stage could take data");

  // Accepted transaction lands in the input register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_vld_q && in_word_q == $past(instruction_word_i)))
    else $error("accepted transaction not captured");

  // Result code agrees with the carried word for halt
  a_hlt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_op_q == a64dec_pkg::OP_HLT) |->
      (word_passthrough_o[31:21] == a64dec_pkg::HltTop11))
    else $error("HLT code with non-HLT word");

  // Codes stay within the defined range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (operation_code_o <= 6'(a64dec_pkg::OP_LDURH)))
    else $error("operation code out of range");

endmodule

// ===== test/arm64_subset_opcode_decoder_chk.sv =====
// Checker for the AArch64 subset decoder: predicts each decode and compares results.
`timescale 1ns / 100ps

module arm64_subset_opcode_decoder_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] instruction_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [5:0]  operation_code_i,
  input  logic [31:0] word_passthrough_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    a64dec_pkg::op_e op;
    logic [31:0]     word;
  } decoded_t;

  decoded_t pending_decodes [$];

  // Expected operation for one instruction word, first match wins
  function automatic a64dec_pkg::op_e decode_word(input logic [31:0] w);
    logic [7:0]  top8;
    logic [10:0] top11;
    logic        rd_zr;
    logic [6:0]  imms_next;
    top8      = w[31:24];
    top11     = w[31:21];
    rd_zr     = (w[4:0] == a64dec_pkg::RegZr);
    imms_next = {1'b0, w[15:10]} + 7'd1;

    if (top11 == a64dec_pkg::HltTop11) return a64dec_pkg::OP_HLT;
    if (w[31:26] == a64dec_pkg::BTop6) return a64dec_pkg::OP_B;
    if (w[31:10] == a64dec_pkg::BrMid22 && w[4:0] == 5'd0) return a64dec_pkg::OP_BR;
    // Shift aliases of UBFM; a non-alias falls through
    if (w[31:22] == a64dec_pkg::UbfmTop10) begin
      if (w[15:10] == a64dec_pkg::ImmsAll) return a64dec_pkg::OP_LSR;
      if (imms_next == {1'b0, w[21:16]}) return a64dec_pkg::OP_LSL;
    end
    // MOVZ only with hw zero
    if (w[31:23] == a64dec_pkg::MovzTop9 && w[22:21] == 2'b00) return a64dec_pkg::OP_MOVZ;

    case (top8)
      a64dec_pkg::TopAddI:  return a64dec_pkg::OP_ADDI;
      a64dec_pkg::TopAddsI: return a64dec_pkg::OP_ADDSI;
      a64dec_pkg::TopSubsI: return rd_zr ? a64dec_pkg::OP_CMPI : a64dec_pkg::OP_SUBSI;
      a64dec_pkg::TopBCond: begin
        // Unsupported condition ends the decode as unknown
        case (w[3:0])
          a64dec_pkg::CondEq: return a64dec_pkg::OP_BEQ;
          a64dec_pkg::CondNe: return a64dec_pkg::OP_BNE;
          a64dec_pkg::CondGe: return a64dec_pkg::OP_BGE;
          a64dec_pkg::CondLt: return a64dec_pkg::OP_BLT;
          a64dec_pkg::CondGt: return a64dec_pkg::OP_BGT;
          a64dec_pkg::CondLe: return a64dec_pkg::OP_BLE;
          default:            return a64dec_pkg::OP_UNKNOWN;
        endcase
      end
      a64dec_pkg::TopCbz:   return a64dec_pkg::OP_CBZ;
      a64dec_pkg::TopCbnz:  return a64dec_pkg::OP_CBNZ;
      default: ;
    endcase

    case (top11)
      a64dec_pkg::TopAddX:  return a64dec_pkg::OP_ADDX;
      a64dec_pkg::TopAddsX: return a64dec_pkg::OP_ADDSX;
      a64dec_pkg::TopSubsX: return rd_zr ? a64dec_pkg::OP_CMPX : a64dec_pkg::OP_SUBSX;
      a64dec_pkg::TopAnds:  return a64dec_pkg::OP_ANDS;
      a64dec_pkg::TopEor:   return a64dec_pkg::OP_EOR;
      a64dec_pkg::TopOrr:   return a64dec_pkg::OP_ORR;
      a64dec_pkg::TopMul:   return a64dec_pkg::OP_MUL;
      a64dec_pkg::TopStur:  return a64dec_pkg::OP_STUR;
      a64dec_pkg::TopSturb: return a64dec_pkg::OP_STURB;
      a64dec_pkg::TopSturh: return a64dec_pkg::OP_STURH;
      a64dec_pkg::TopLdur:  return a64dec_pkg::OP_LDUR;
      a64dec_pkg::TopLdurb: return a64dec_pkg::OP_LDURB;
      a64dec_pkg::TopLdurh: return a64dec_pkg::OP_LDURH;
      default: ;
    endcase

    return a64dec_pkg::OP_UNKNOWN;
  endfunction

  // One line per mismatch, and a count
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  initial begin
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  // Retire result transactions first, then queue new predictions
  always @(posedge clk_i) begin
    decoded_t exp;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("unexpected result", word_passthrough_i, 32'd0);
        end else begin
          exp = pending_decodes.pop_front();
          if (operation_code_i !== exp.op) begin
            report_mismatch("operation_code", {26'd0, operation_code_i}, {26'd0, exp.op});
          end
          if (word_passthrough_i !== exp.word) begin
            report_mismatch("word_passthrough", word_passthrough_i, exp.word);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp.op   = decode_word(instruction_word_i);
        exp.word = instruction_word_i;
        pending_decodes.push_back(exp);
      end
      pending_count_o <= pending_decodes.size();
    end
  end

endmodule

// ===== test/arm64_subset_opcode_decoder_tb.sv =====
// Testbench top for the AArch64 subset decoder: stimulus, stall pattern and verdict.
`timescale 1ns / 100ps

module arm64_subset_opcode_decoder_tb;

  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CycleLimit  = 400000;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic [31:0] instruction_word_i = 32'd0;
  logic        out_stall_i        = 1'b0;
  logic        calm               = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [5:0]  operation_code_o;
  logic [31:0] word_passthrough_o;
  int          mismatch_count;
  int          pending_count;
  int unsigned cycle_count = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  arm64_subset_opcode_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .instruction_word_i (instruction_word_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .operation_code_o   (operation_code_o),
    .word_passthrough_o (word_passthrough_o)
  );

  arm64_subset_opcode_decoder_chk u_chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .instruction_word_i (instruction_word_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .operation_code_i   (operation_code_o),
    .word_passthrough_i (word_passthrough_o),
    .mismatch_count_o   (mismatch_count),
    .pending_count_o    (pending_count)
  );

  // Receiver stalls about a quarter of the cycles, never during the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 26);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one word, with random idle cycles ahead of it, and hold it until taken
  task automatic send_word(input logic [31:0] w);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i         <= 1'b1;
    instruction_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Mostly words that hit a decode pattern, with random remaining bits
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned pick;
    logic [7:0]  tops8 [6];
    logic [10:0] tops11 [13];
    tops8  = '{a64dec_pkg::TopAddI, a64dec_pkg::TopAddsI, a64dec_pkg::TopSubsI,
               a64dec_pkg::TopBCond, a64dec_pkg::TopCbz, a64dec_pkg::TopCbnz};
    tops11 = '{a64dec_pkg::TopAddX, a64dec_pkg::TopAddsX, a64dec_pkg::TopSubsX,
               a64dec_pkg::TopAnds, a64dec_pkg::TopEor, a64dec_pkg::TopOrr,
               a64dec_pkg::TopMul, a64dec_pkg::TopStur, a64dec_pkg::TopSturb,
               a64dec_pkg::TopSturh, a64dec_pkg::TopLdur, a64dec_pkg::TopLdurb,
               a64dec_pkg::TopLdurh};
    w    = $urandom;
    pick = $urandom_range(99);
    if (pick < 6) begin
      w[31:21] = a64dec_pkg::HltTop11;
    end else if (pick < 11) begin
      w[31:26] = a64dec_pkg::BTop6;
    end else if (pick < 16) begin
      w[31:10] = a64dec_pkg::BrMid22;
      if ($urandom_range(3) != 0) w[4:0] = 5'd0;
    end else if (pick < 24) begin
      w[31:22] = a64dec_pkg::UbfmTop10;
      case ($urandom_range(2))
        0: w[15:10] = a64dec_pkg::ImmsAll;
        1: w[21:16] = w[15:10] + 6'd1;
        default: ;
      endcase
    end else if (pick < 30) begin
      w[31:23] = a64dec_pkg::MovzTop9;
      if ($urandom_range(1) == 1) w[22:21] = 2'b00;
    end else if (pick < 55) begin
      w[31:24] = tops8[$urandom_range(5)];
    end else if (pick < 85) begin
      w[31:21] = tops11[$urandom_range(12)];
    end
    // Zero register as destination selects the compare forms
    if ($urandom_range(3) == 0) w[4:0] = a64dec_pkg::RegZr;
    return w;
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{
      32'h0000_0000, 32'hFFFF_FFFF,
      {a64dec_pkg::HltTop11, 21'h0A5A5},
      {a64dec_pkg::BTop6, 26'h3FF_FFFF},
      {a64dec_pkg::BrMid22, 5'd3, 5'd0},
      {a64dec_pkg::BrMid22, 5'd3, 5'd1},
      {a64dec_pkg::UbfmTop10, 6'd5, a64dec_pkg::ImmsAll, 10'h000},
      {a64dec_pkg::UbfmTop10, 6'd8, 6'd7, 10'h021},
      {a64dec_pkg::UbfmTop10, 6'd3, 6'd9, 10'h021},
      {a64dec_pkg::MovzTop9, 2'b00, 21'h1ABCD},
      {a64dec_pkg::MovzTop9, 2'b01, 21'h1ABCD},
      {a64dec_pkg::TopAddI, 24'h123456},
      {a64dec_pkg::TopAddsI, 24'h000001},
      {a64dec_pkg::TopSubsI, 19'h0, a64dec_pkg::RegZr},
      {a64dec_pkg::TopSubsI, 24'h00001E},
      {a64dec_pkg::TopBCond, 20'h0, a64dec_pkg::CondEq},
      {a64dec_pkg::TopBCond, 20'h0, a64dec_pkg::CondNe},
      {a64dec_pkg::TopBCond, 20'h0, a64dec_pkg::CondGe},
      {a64dec_pkg::TopBCond, 20'h0, a64dec_pkg::CondLt},
      {a64dec_pkg::TopBCond, 20'h0, a64dec_pkg::CondGt},
      {a64dec_pkg::TopBCond, 20'h0, a64dec_pkg::CondLe},
      {a64dec_pkg::TopBCond, 20'h0, 4'h2},
      {a64dec_pkg::TopCbz, 24'h0},
      {a64dec_pkg::TopCbnz, 24'hFFFFFF},
      {a64dec_pkg::TopAddX, 21'h0},
      {a64dec_pkg::TopAddsX, 21'h0},
      {a64dec_pkg::TopSubsX, 16'h0, a64dec_pkg::RegZr},
      {a64dec_pkg::TopSubsX, 21'h0},
      {a64dec_pkg::TopAnds, 21'h0},
      {a64dec_pkg::TopEor, 21'h0},
      {a64dec_pkg::TopOrr, 21'h0},
      {a64dec_pkg::TopMul, 21'h0},
      {a64dec_pkg::TopStur, 21'h0},
      {a64dec_pkg::TopSturb, 21'h0},
      {a64dec_pkg::TopSturh, 21'h0},
      {a64dec_pkg::TopLdur, 21'h0},
      {a64dec_pkg::TopLdurb, 21'h0},
      {a64dec_pkg::TopLdurh, 21'h1FFFFF}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_word(directed[i]);

    // Drain completely before the random part
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      calm <= (i >= 1000 && i < 1300);
      send_word(random_word());
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
